// File: rtl/ccp_pkg.sv
// Shared types, constants and rounding helpers for the climate control predictor.
// No dependencies; imported by every rtl module.
`default_nettype none
package ccp_pkg;

    localparam int VALUE_FRAC_BITS = 16;
    localparam int GAIN_FRAC_BITS  = 32;
    localparam int COEF_FRAC       = 24;
    localparam int MUL_W           = 34;
    localparam int ACC_W           = 64;
    localparam int COV_W           = 42;
    localparam int REM_W           = 45;
    localparam int DVS_W           = 44;
    localparam int NUM_W           = 24;
    localparam int QUO_W           = 32;
    localparam int CNT_W           = 6;
    localparam int IN_W            = 112;
    localparam int OUT_W           = 216;

    // n/29 as (n * ceil(2^29/29)) >> 29, exact for n below 2^24
    localparam int RECIP_SHIFT     = 29;
    localparam int RPROD_W         = 49;
    localparam logic [RPROD_W-NUM_W-1:0] RECIP_29 = 25'd18512791;

    // forgetting factor, G fraction bits
    localparam logic [DVS_W-1:0] LAMBDA_Q = DVS_W'((64'd1 << GAIN_FRAC_BITS)
        - ((64'd7 << GAIN_FRAC_BITS) + 64'd5000) / 64'd10000);

    localparam logic signed [MUL_W-1:0] K_AP_T     = 34'sd438324901;
    localparam logic signed [MUL_W-1:0] K_AP_H     = 34'sd13173470;
    localparam logic signed [MUL_W-1:0] K_MI_T     = 34'sd28452481;
    localparam logic signed [MUL_W-1:0] K_MI_H     = 34'sd1105619;
    localparam logic signed [MUL_W-1:0] K_T3       = 34'sd789771;
    localparam logic signed [MUL_W-1:0] K_T4       = 34'sd23334;
    localparam logic signed [MUL_W-1:0] K_TD       = 34'sd389024;
    localparam logic signed [MUL_W-1:0] K_LUM      = 34'sd7184;
    localparam logic signed [MUL_W-1:0] K_TMIST    = 34'sd2315256;
    localparam logic signed [MUL_W-1:0] K_HI       = 34'sd14705230;
    localparam logic signed [MUL_W-1:0] K_HO       = 34'sd3442685;
    localparam logic signed [MUL_W-1:0] K_HAP      = 34'sd26865356;
    localparam logic signed [MUL_W-1:0] K_HFAN     = 34'sd3707765;
    localparam logic signed [MUL_W-1:0] K_HMIST_HI = 34'sd336228830;
    localparam logic signed [MUL_W-1:0] K_HMIST_LO = 34'sd301989888;
    localparam logic signed [MUL_W-1:0] K_HT       = 34'sd667733;

    localparam logic [23:0] TEMP_SP_RESET = 24'd1638400;
    localparam logic [22:0] HUM_SP_RESET  = 23'd3932160;
    localparam logic [24:0] TEMP_PRED_RESET = 25'd1638400;
    localparam logic [24:0] HUM_PRED_RESET  = 25'd3276800;
    localparam logic [COV_W-1:0] COV_RESET = COV_W'(64'd1000 << GAIN_FRAC_BITS);

    localparam logic [0:0] REG_TEMP_SP = 1'b0;
    localparam logic [0:0] REG_HUM_SP  = 1'b1;

    typedef enum logic {
        DSEL_T = 1'b0,
        DSEL_H = 1'b1
    } div_sel_t;

    typedef enum logic [4:0] {
        OP_AP_T, OP_AP_H, OP_MI_T, OP_MI_H, OP_TD, OP_LUM, OP_TMIST,
        OP_T3, OP_T4, OP_T3AP, OP_T4FAN, OP_HI, OP_HO, OP_HT,
        OP_RAP, OP_RFAN, OP_HAP, OP_HFAN, OP_HMIST, OP_TAVG, OP_HAVG
    } op_t;

    typedef struct packed {
        logic     load;
        logic     div_go;
        div_sel_t div_sel;
        op_t      op;
        logic     exec;
        logic     commit;
    } ccp_cmd_t;

    typedef struct packed {
        logic div_done;
    } ccp_stat_t;

    function automatic logic signed [ACC_W-1:0] rnd_coef(input logic signed [ACC_W-1:0] x);
        return (x + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function automatic logic signed [ACC_W-1:0] rnd_val(input logic signed [ACC_W-1:0] x);
        return (x + (64'sd1 <<< (VALUE_FRAC_BITS - 1))) >>> VALUE_FRAC_BITS;
    endfunction

    function automatic logic [24:0] sat25(input logic signed [ACC_W-1:0] x);
        logic [24:0] r;
        if (x < -64'sd16777216)     r = 25'h1000000;
        else if (x > 64'sd16777215) r = 25'h0FFFFFF;
        else                        r = x[24:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ccp_div.sv
// Restoring divider, one quotient bit per cycle; shared by both gains.
// Depends on ccp_pkg.
`default_nettype none
module ccp_div
    import ccp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             go,
    input  wire logic [REM_W-1:0] rem_init,
    input  wire logic [DVS_W-1:0] divisor,
    input  wire logic [CNT_W-1:0] steps,
    output logic      [QUO_W-1:0] quot,
    output logic                  done
);

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [REM_W-1:0] rem_sh;

    always_comb begin
        rem_sh   = {rem_reg[REM_W-2:0], 1'b0};
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (go) begin
            rem_next = rem_init;
            dvs_next = divisor;
            quo_next = '0;
            cnt_next = steps;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quot = quo_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// File: rtl/ccp_datapath.sv
// Datapath: sample and setpoint registers, shared multiplier and accumulator,
// predictor state and result word register. Depends on ccp_pkg and ccp_div.
`default_nettype none
module ccp_datapath
    import ccp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             cfg_wr_en,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [23:0]      cfg_wdata,
    input  wire ccp_cmd_t         cmd,
    output ccp_stat_t             stat,
    output logic      [OUT_W-1:0] m_tdata
);

    logic signed [23:0] ti_reg, to_reg, tsp_reg;
    logic [22:0] hi_reg, ho_reg, hsp_reg;
    logic [16:0] lum_reg;

    logic [24:0] tpred_reg, hpred_reg, tavg_reg, havg_reg;
    logic [COV_W-1:0] tcov_reg, hcov_reg;

    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, apraw_reg, tacc_reg;
    logic signed [MUL_W-1:0]   t3_reg, t4_reg, ra_reg, rf_reg, r_reg;
    logic [RPROD_W-1:0] rprod_reg;
    logic [16:0] mist_reg;
    logic [24:0] tp_new_reg, hp_new_reg, tavg_new_reg, havg_new_reg;
    logic [QUO_W-1:0] kt_reg, kh_reg;
    logic [OUT_W-1:0] out_reg;

    logic signed [24:0] te, d;
    logic signed [23:0] he, dh;
    logic [22:0] dh_mag;
    logic [NUM_W-1:0] r_num;
    logic hi_branch;
    logic [18:0] ap;
    logic [22:0] fan;
    logic signed [ACC_W-1:0] ovf, p, ti_ext;
    logic [24:0] terr, herr;
    logic [25:0] ut, uh;
    logic tneg, hneg;
    logic signed [MUL_W-1:0] mul_a, mul_b;

    logic [REM_W-1:0] d_rem;
    logic [DVS_W-1:0] d_dvs;
    logic [CNT_W-1:0] d_steps;
    logic [QUO_W-1:0] quot;
    logic             div_done;

    function automatic logic [24:0] abs_err(input logic [24:0] pred, input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] df;
        df = ACC_W'($signed(pred)) - x;
        if (df < 0) df = -df;
        return (df > 64'sd33554431) ? 25'h1FFFFFF : df[24:0];
    endfunction

    function automatic logic [24:0] avg_step(input logic [24:0] theta, input logic neg,
                                             input logic signed [ACC_W-1:0] prod);
        logic [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] v;
        r = ((ACC_W'(prod) >> 20) + 64'd2048) >> 12;
        v = neg ? ($signed(ACC_W'(theta)) - $signed(r)) : ($signed(ACC_W'(theta)) + $signed(r));
        if (v < 0) return 25'd0;
        if (v > 64'sd33554431) return 25'h1FFFFFF;
        return v[24:0];
    endfunction

    always_comb begin
        te = {tsp_reg[23], tsp_reg} - {ti_reg[23], ti_reg};
        he = $signed({1'b0, hsp_reg}) - $signed({1'b0, hi_reg});
        d  = {ti_reg[23], ti_reg} - {to_reg[23], to_reg};
        dh = $signed({1'b0, hi_reg}) - $signed({1'b0, ho_reg});
        dh_mag = dh[23] ? 23'(-dh) : dh[22:0];
        r_num = NUM_W'(dh_mag) + NUM_W'(14);
        hi_branch = (dh >= 24'sd1966080);
        ti_ext = ACC_W'(ti_reg);
        p = prod_reg[ACC_W-1:0];

        if (apraw_reg < 0)                 ap = '0;
        else if (apraw_reg > 64'sd262144)  ap = 19'd262144;
        else                               ap = apraw_reg[18:0];
        ovf = (apraw_reg - ACC_W'(ap)) <<< 2;
        if (ovf < 0)                       fan = '0;
        else if (ovf > 64'sd6553600)       fan = 23'd6553600;
        else                               fan = ovf[22:0];

        terr = abs_err(tpred_reg, ti_ext);
        herr = abs_err(hpred_reg, ACC_W'(hi_reg));
        ut = {1'b0, terr} - {1'b0, tavg_reg};
        tneg = ut[25];
        if (tneg) ut = -ut;
        uh = {1'b0, herr} - {1'b0, havg_reg};
        hneg = uh[25];
        if (hneg) uh = -uh;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_AP_T:  begin mul_a = -K_AP_T;  mul_b = MUL_W'(te); end
            OP_AP_H:  begin mul_a = K_AP_H;   mul_b = MUL_W'(he); end
            OP_MI_T:  begin mul_a = -K_MI_T;  mul_b = MUL_W'(te); end
            OP_MI_H:  begin mul_a = K_MI_H;   mul_b = MUL_W'(he); end
            OP_TD:    begin mul_a = -K_TD;    mul_b = MUL_W'(d); end
            OP_LUM:   begin mul_a = K_LUM;    mul_b = MUL_W'(lum_reg); end
            OP_TMIST: begin mul_a = -K_TMIST; mul_b = MUL_W'(mist_reg); end
            OP_T3:    begin mul_a = -K_T3;    mul_b = MUL_W'(d); end
            OP_T4:    begin mul_a = -K_T4;    mul_b = MUL_W'(d); end
            OP_T3AP:  begin mul_a = t3_reg;   mul_b = MUL_W'(ap); end
            OP_T4FAN: begin mul_a = t4_reg;   mul_b = MUL_W'(fan); end
            OP_HI:    begin mul_a = K_HI;     mul_b = MUL_W'(hi_reg); end
            OP_HO:    begin mul_a = K_HO;     mul_b = MUL_W'(ho_reg); end
            OP_HT:    begin mul_a = -K_HT;    mul_b = MUL_W'(ti_reg); end
            OP_RAP:   begin mul_a = r_reg;    mul_b = MUL_W'(ap); end
            OP_RFAN:  begin mul_a = r_reg;    mul_b = MUL_W'(fan); end
            OP_HAP:   begin
                mul_a = -K_HAP;
                mul_b = hi_branch ? MUL_W'(ap) : ra_reg;
            end
            OP_HFAN:  begin
                mul_a = -K_HFAN;
                mul_b = hi_branch ? MUL_W'(fan) : rf_reg;
            end
            OP_HMIST: begin
                mul_a = hi_branch ? K_HMIST_HI : K_HMIST_LO;
                mul_b = MUL_W'(mist_reg);
            end
            OP_TAVG:  begin mul_a = MUL_W'(ut); mul_b = MUL_W'(kt_reg); end
            OP_HAVG:  begin mul_a = MUL_W'(uh); mul_b = MUL_W'(kh_reg); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // divider operands: the two gains P/(lambda+P)
    always_comb begin
        d_steps = CNT_W'(GAIN_FRAC_BITS);
        case (cmd.div_sel)
            DSEL_H: begin
                d_rem = REM_W'(hcov_reg);
                d_dvs = LAMBDA_Q + DVS_W'(hcov_reg);
            end
            default: begin
                d_rem = REM_W'(tcov_reg);
                d_dvs = LAMBDA_Q + DVS_W'(tcov_reg);
            end
        endcase
    end

    ccp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (cmd.div_go),
        .rem_init (d_rem),
        .divisor  (d_dvs),
        .steps    (d_steps),
        .quot     (quot),
        .done     (div_done)
    );

    assign stat.div_done = div_done;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        // rounded dh/29 by reciprocal multiply; registered in rprod_reg, then in r_reg
        rprod_reg <= r_num * RECIP_29;
        r_reg <= dh[23] ? -MUL_W'(rprod_reg[RPROD_W-1:RECIP_SHIFT])
                        : MUL_W'(rprod_reg[RPROD_W-1:RECIP_SHIFT]);
        if (cmd.load) begin
            ti_reg  <= s_tdata[23:0];
            to_reg  <= s_tdata[47:24];
            hi_reg  <= s_tdata[70:48];
            ho_reg  <= s_tdata[93:71];
            lum_reg <= s_tdata[110:94];
        end
        if (div_done) begin
            case (cmd.div_sel)
                DSEL_H:  kh_reg <= quot;
                default: kt_reg <= quot;
            endcase
        end
        if (cmd.exec) begin
            case (cmd.op)
                OP_AP_T, OP_MI_T, OP_TD, OP_T3AP, OP_HI: acc_reg <= p;
                OP_AP_H:  apraw_reg <= rnd_coef(acc_reg + p);
                OP_MI_H:  begin
                    if (rnd_coef(acc_reg + p) < 0)               mist_reg <= '0;
                    else if (rnd_coef(acc_reg + p) > 64'sd65536) mist_reg <= 17'd65536;
                    else mist_reg <= 17'(rnd_coef(acc_reg + p));
                end
                OP_LUM:   acc_reg <= acc_reg + (p <<< VALUE_FRAC_BITS);
                OP_TMIST: tacc_reg <= rnd_coef(acc_reg + p);
                OP_T3:    t3_reg <= d[24] ? '0 : MUL_W'(rnd_coef(p));
                OP_T4:    t4_reg <= d[24] ? '0 : MUL_W'(rnd_coef(p));
                OP_T4FAN: tp_new_reg <= sat25(ti_ext + tacc_reg + rnd_val(acc_reg + p));
                OP_HO, OP_HT, OP_HAP, OP_HFAN: acc_reg <= acc_reg + p;
                OP_RAP:   ra_reg <= MUL_W'(rnd_val(p));
                OP_RFAN:  rf_reg <= MUL_W'(rnd_val(p));
                OP_HMIST: hp_new_reg <= sat25(rnd_coef(acc_reg + p)
                                              + (64'sd2 <<< VALUE_FRAC_BITS));
                OP_TAVG:  tavg_new_reg <= avg_step(tavg_reg, tneg, p);
                OP_HAVG:  havg_new_reg <= avg_step(havg_reg, hneg, p);
                default:  acc_reg <= acc_reg;
            endcase
        end
        if (cmd.commit) begin
            out_reg <= {7'd0, havg_new_reg, tavg_new_reg, herr, terr,
                        hpred_reg, tpred_reg, mist_reg, fan, ap};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsp_reg   <= TEMP_SP_RESET;
            hsp_reg   <= HUM_SP_RESET;
            tpred_reg <= TEMP_PRED_RESET;
            hpred_reg <= HUM_PRED_RESET;
            tcov_reg  <= COV_RESET;
            hcov_reg  <= COV_RESET;
            tavg_reg  <= '0;
            havg_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TEMP_SP: tsp_reg <= cfg_wdata;
                    REG_HUM_SP:  hsp_reg <= cfg_wdata[22:0];
                    default:     tsp_reg <= tsp_reg;
                endcase
            end
            if (cmd.commit) begin
                tpred_reg <= tp_new_reg;
                hpred_reg <= hp_new_reg;
                tcov_reg  <= COV_W'(kt_reg);
                hcov_reg  <= COV_W'(kh_reg);
                tavg_reg  <= tavg_new_reg;
                havg_reg  <= havg_new_reg;
            end
        end
    end

    assign m_tdata = out_reg;

endmodule
`default_nettype wire

// File: rtl/ccp_ctrl.sv
// Controller: sequences the two gain divisions and the multiplier operations,
// owns the stream handshakes. Depends on ccp_pkg.
`default_nettype none
module ccp_ctrl
    import ccp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire ccp_stat_t stat,
    output ccp_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV_T = 5'b00010,
        ST_DIV_H = 5'b00100,
        ST_OPS   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   phase_reg, phase_next;
    logic   go_reg, go_next;
    logic   valid_reg, valid_next;
    logic   out_load;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        phase_next = 1'b0;
        go_next    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DIV_T;
                    go_next = 1'b1;
                end
            end
            ST_DIV_T: begin
                if (stat.div_done) begin
                    state_next = ST_DIV_H;
                    go_next = 1'b1;
                end
            end
            ST_DIV_H: begin
                if (stat.div_done) begin
                    state_next = ST_OPS;
                    op_next = OP_AP_T;
                end
            end
            ST_OPS: begin
                // phase 0 loads the product register, phase 1 acts on it
                phase_next = !phase_reg;
                if (phase_reg) begin
                    if (op_reg == OP_HAVG) state_next = ST_DONE;
                    else op_next = op_t'(op_reg + 5'd1);
                end
            end
            ST_DONE: begin
                if (!valid_reg || m_tready) begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (out_load)      valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_AP_T;
            phase_reg <= 1'b0;
            go_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            phase_reg <= phase_next;
            go_reg    <= go_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        cmd.load   = s_tvalid && (state_reg == ST_IDLE);
        cmd.div_go = go_reg;
        case (state_reg)
            ST_DIV_H: cmd.div_sel = DSEL_H;
            default:  cmd.div_sel = DSEL_T;
        endcase
        cmd.op     = op_reg;
        cmd.exec   = (state_reg == ST_OPS) && phase_reg;
        cmd.commit = out_load;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

endmodule
`default_nettype wire

// File: rtl/climate_control_predictor.sv
// Climate control predictor: one result word per sample word.
// From input accept to result valid: two restoring gain divisions (32 steps each),
// then 21 operations on one shared multiplier, each loading the product and then
// acting on it, then a load of the result register.
// A new sample is taken only in idle, after the last result is loaded; a finished
// result may wait in the output register while the next sample is taken. aresetn
// (synchronous, active low) restores setpoints, predictions, covariances, averages.
`default_nettype none
module climate_control_predictor
    import ccp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // temp_inside, temp_outside, hum_inside, hum_outside, light_level, pad
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // aperture_drive, fan_drive, mist_drive, temp_prediction_prev,
    // hum_prediction_prev, temp_abs_error, hum_abs_error,
    // temp_error_average, hum_error_average, pad
    output logic      [OUT_W-1:0]  m_tdata,
    input  wire logic              cfg_wr_en,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [23:0]       cfg_wdata
);

    ccp_cmd_t  cmd;
    ccp_stat_t stat;

    ccp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ccp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// File: rtl/ccp_checker.sv
// Port-level checks for climate_control_predictor, bound to the top level.
// Depends on ccp_pkg.
`default_nettype none
module ccp_checker
    import ccp_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    a_reset_clears_valid: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared without computation");

endmodule

bind climate_control_predictor ccp_checker u_ccp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
